// ----- sv/sirt_pkg.sv -----
// shared types, constants and microcode program of the radix text converter
package sirt_pkg;

  localparam int MAX_RADIX  = 16;
  localparam int VALUE_BITS = 32;

  localparam int TABLE_SIZE = 16;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int BASE_LEN_W = 5;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;

  localparam int DIG_W      = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1;
  localparam int REM_W      = DIG_W + 1;
  localparam int DIV_CHUNK  = 8;
  localparam int DIV_STEPS  = (VALUE_BITS + DIV_CHUNK - 1) / DIV_CHUNK;
  localparam int MAG_W      = DIV_STEPS * DIV_CHUNK;
  localparam int DIV_CNT_W  = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
  localparam int DEPTH      = VALUE_BITS;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  localparam logic [7:0] MINUS_CHAR = 8'h2D;
  localparam logic [7:0] PLUS_CHAR  = 8'h2B;
  localparam logic [7:0] NUL_CHAR   = 8'h00;

  localparam logic [CFG_IDX_W-1:0] REG_DIGITS_LOW  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DIGITS_HIGH = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_BASE_LENGTH = CFG_IDX_W'(2);

  localparam int PC_W = 4;

  localparam logic [PC_W-1:0] PC_IDLE      = PC_W'(0);
  localparam logic [PC_W-1:0] PC_CHECK     = PC_W'(1);
  localparam logic [PC_W-1:0] PC_TEST      = PC_W'(2);
  localparam logic [PC_W-1:0] PC_DIV_INIT  = PC_W'(3);
  localparam logic [PC_W-1:0] PC_DIV       = PC_W'(4);
  localparam logic [PC_W-1:0] PC_PUSH      = PC_W'(5);
  localparam logic [PC_W-1:0] PC_SIGN_TEST = PC_W'(6);
  localparam logic [PC_W-1:0] PC_SIGN      = PC_W'(7);
  localparam logic [PC_W-1:0] PC_DIGIT     = PC_W'(8);
  localparam logic [PC_W-1:0] PC_DONE      = PC_W'(9);

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_ACCEPT,
    CMD_CHECK,
    CMD_DIV_INIT,
    CMD_DIV_STEP,
    CMD_PUSH,
    CMD_EMIT_SIGN,
    CMD_EMIT_DIGIT
  } cmd_t;

  typedef enum logic [3:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_CHK_MORE,
    COND_BAD,
    COND_DIV_MORE,
    COND_MAG_NZ,
    COND_POS,
    COND_OUT_BUSY,
    COND_DIGITS_LEFT
  } cond_t;

  typedef struct packed {
    cmd_t            cmd;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic in_fire;
    logic chk_more;
    logic bad;
    logic div_more;
    logic mag_nz;
    logic neg;
    logic out_free;
    logic last_digit;
  } status_t;

  // control store: conditional jump to target when cond holds, else fall through
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    unique case (pc)
      PC_IDLE:      w = '{CMD_ACCEPT,     COND_NO_INPUT,    PC_IDLE};
      PC_CHECK:     w = '{CMD_CHECK,      COND_CHK_MORE,    PC_CHECK};
      PC_TEST:      w = '{CMD_NONE,       COND_BAD,         PC_IDLE};
      PC_DIV_INIT:  w = '{CMD_DIV_INIT,   COND_NEXT,        PC_IDLE};
      PC_DIV:       w = '{CMD_DIV_STEP,   COND_DIV_MORE,    PC_DIV};
      PC_PUSH:      w = '{CMD_PUSH,       COND_MAG_NZ,      PC_DIV_INIT};
      PC_SIGN_TEST: w = '{CMD_NONE,       COND_POS,         PC_DIGIT};
      PC_SIGN:      w = '{CMD_EMIT_SIGN,  COND_OUT_BUSY,    PC_SIGN};
      PC_DIGIT:     w = '{CMD_EMIT_DIGIT, COND_DIGITS_LEFT, PC_DIGIT};
      PC_DONE:      w = '{CMD_NONE,       COND_ALWAYS,      PC_IDLE};
      default:      w = '{CMD_NONE,       COND_ALWAYS,      PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ----- sv/sirt_sequencer.sv -----
// microcode sequencer: step counter, control store and jump logic
module sirt_sequencer (
  input  logic             clk,
  input  logic             rst,
  input  sirt_pkg::status_t status,
  output sirt_pkg::cmd_t    cmd
);
  import sirt_pkg::*;

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  ucode_t          word;
  logic            take;

  assign word = ucode_rom(pc);
  assign cmd  = word.cmd;

  always_comb begin
    unique case (word.cond)
      COND_NEXT:        take = 1'b0;
      COND_ALWAYS:      take = 1'b1;
      COND_NO_INPUT:    take = !status.in_fire;
      COND_CHK_MORE:    take = status.chk_more;
      COND_BAD:         take = status.bad;
      COND_DIV_MORE:    take = status.div_more;
      COND_MAG_NZ:      take = status.mag_nz;
      COND_POS:         take = !status.neg;
      COND_OUT_BUSY:    take = !status.out_free;
      COND_DIGITS_LEFT: take = !(status.out_free && status.last_digit);
      default:          take = 1'b1;
    endcase
    pc_next = take ? word.target : pc + PC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// ----- sv/sirt_datapath.sv -----
// datapath: config registers, base check, chunked divider, digit stack, output register
module sirt_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  sirt_pkg::cmd_t                       cmd,
  output sirt_pkg::status_t                    status,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [sirt_pkg::VALUE_BITS-1:0] value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [7:0]                           text_char,
  output logic                                 last_char,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [sirt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sirt_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import sirt_pkg::*;

  logic [CFG_DATA_W-1:0] digit_chars_low;
  logic [CFG_DATA_W-1:0] digit_chars_high;
  logic [BASE_LEN_W-1:0] base_length;

  logic [7:0]            chars [TABLE_SIZE];
  logic                  neg;
  logic [MAG_W-1:0]      mag;
  logic [MAG_W-1:0]      mag_div;
  logic [DIG_W-1:0]      rem;
  logic [DIG_W-1:0]      rem_div;
  logic [DIV_CNT_W-1:0]  div_cnt;
  logic [IDX_W-1:0]      idx;
  logic                  bad;
  logic                  chk_fault;
  logic [DIG_W-1:0]      stk [DEPTH];
  logic [CNT_W-1:0]      ndig;
  logic [VALUE_BITS-1:0] abs_val;
  logic [REM_W-1:0]      radix;
  logic                  in_fire;
  logic                  out_free;
  logic                  emit_sign;
  logic                  emit_digit;

  assign cfg_ready  = 1'b1;
  assign in_ready   = (cmd == CMD_ACCEPT);
  assign in_fire    = in_valid && in_ready;
  assign out_free   = !out_valid || out_ready;
  assign emit_sign  = (cmd == CMD_EMIT_SIGN) && out_free;
  assign emit_digit = (cmd == CMD_EMIT_DIGIT) && out_free;
  assign radix      = base_length[REM_W-1:0];
  assign abs_val    = value[VALUE_BITS-1] ? (VALUE_BITS'(0) - VALUE_BITS'(value))
                                          : VALUE_BITS'(value);

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      chars[i]     = digit_chars_low[8*i +: 8];
      chars[i + 8] = digit_chars_high[8*i +: 8];
    end
  end

  // one table entry per step: forbidden byte or equal to an earlier entry
  always_comb begin
    logic [7:0] cur;
    logic       dup;
    cur = chars[idx];
    dup = 1'b0;
    for (int b = 0; b < TABLE_SIZE; b++) begin
      if ((IDX_W'(b) < idx) && (chars[b] == cur)) dup = 1'b1;
    end
    chk_fault = (BASE_LEN_W'(idx) < base_length) &&
                (dup || cur == NUL_CHAR || cur == PLUS_CHAR || cur == MINUS_CHAR);
  end

  // restoring division, DIV_CHUNK quotient bits per cycle
  always_comb begin
    logic [DIG_W-1:0] r;
    logic [MAG_W-1:0] m;
    logic [REM_W-1:0] sh;
    logic             q;
    r = rem;
    m = mag;
    for (int i = 0; i < DIV_CHUNK; i++) begin
      sh = {r, m[MAG_W-1]};
      q  = (sh >= radix);
      r  = q ? DIG_W'(sh - radix) : sh[DIG_W-1:0];
      m  = {m[MAG_W-2:0], q};
    end
    rem_div = r;
    mag_div = m;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_chars_low  <= '0;
      digit_chars_high <= '0;
      base_length      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DIGITS_LOW:  digit_chars_low  <= cfg_data;
        REG_DIGITS_HIGH: digit_chars_high <= cfg_data;
        REG_BASE_LENGTH: base_length      <= cfg_data[BASE_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx     <= '0;
      bad     <= 1'b0;
      div_cnt <= '0;
      ndig    <= '0;
    end else begin
      if (in_fire) begin
        idx  <= '0;
        bad  <= (base_length < BASE_LEN_W'(2)) ||
                (base_length > BASE_LEN_W'(MAX_RADIX));
        ndig <= '0;
      end
      if (cmd == CMD_CHECK) begin
        idx <= idx + IDX_W'(1);
        if (chk_fault) bad <= 1'b1;
      end
      if (cmd == CMD_DIV_INIT) div_cnt <= '0;
      if (cmd == CMD_DIV_STEP) div_cnt <= div_cnt + DIV_CNT_W'(1);
      if (cmd == CMD_PUSH) ndig <= ndig + CNT_W'(1);
      if (emit_digit) ndig <= ndig - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      neg <= value[VALUE_BITS-1];
      mag <= MAG_W'(abs_val);
    end
    if (cmd == CMD_DIV_INIT) rem <= '0;
    if (cmd == CMD_DIV_STEP) begin
      rem <= rem_div;
      mag <= mag_div;
    end
    // digit stack, top at entry 0
    if (cmd == CMD_PUSH) begin
      stk[0] <= rem;
      for (int i = 1; i < DEPTH; i++) stk[i] <= stk[i-1];
    end else if (emit_digit) begin
      for (int i = 0; i < DEPTH - 1; i++) stk[i] <= stk[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_sign || emit_digit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_sign) begin
      text_char <= MINUS_CHAR;
      last_char <= 1'b0;
    end else if (emit_digit) begin
      text_char <= chars[IDX_W'(stk[0])];
      last_char <= (ndig == CNT_W'(1));
    end
  end

  always_comb begin
    status.in_fire    = in_fire;
    status.chk_more   = (idx != IDX_W'(TABLE_SIZE - 1));
    status.bad        = bad;
    status.div_more   = (div_cnt != DIV_CNT_W'(DIV_STEPS - 1));
    status.mag_nz     = (mag != '0);
    status.neg        = neg;
    status.out_free   = out_free;
    status.last_digit = (ndig == CNT_W'(1));
  end

endmodule

// ----- sv/signed_integer_to_radix_text.sv -----
// top level: signed integer to text in a configurable radix
//
//   channel   handshake              payload                       direction
//   input     in_valid / in_ready    value                         in
//   output    out_valid / out_ready  text_char, last_char          out
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data           in
//
// one number at a time; a request is taken in the idle step only
// base check walks the 16 table entries, one per cycle
// each digit: the remainder is cleared, the magnitude divided by the radix and the
// remainder pushed; divider takes 8 quotient bits per cycle
// the last character waits in the output register while the next request is taken
// synchronous reset clears config, sequencer and output valid; cfg_ready is always high
module signed_integer_to_radix_text (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [sirt_pkg::VALUE_BITS-1:0] value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [7:0]                           text_char,
  output logic                                 last_char,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [sirt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sirt_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import sirt_pkg::*;

  cmd_t    cmd;
  status_t status;

  sirt_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  sirt_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .text_char (text_char),
    .last_char (last_char),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

// ----- sv/sirt_checker.sv -----
// port-level checks for the radix text converter, bound to the top level
module sirt_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] text_char,
  input logic       last_char
);
  import sirt_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(text_char) && $stable(last_char))
    else $error("stalled output changed");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && text_char == MINUS_CHAR |-> !last_char)
    else $error("minus sign flagged as last character");

  a_no_forbidden: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> text_char != NUL_CHAR && text_char != PLUS_CHAR)
    else $error("forbidden character on output");

  a_idle_after_text: assert property (@(posedge clk) disable iff (rst)
    in_ready && out_valid |-> last_char)
    else $error("new request taken before text finished");

endmodule

bind signed_integer_to_radix_text sirt_checker u_sirt_checker (.*);

// ----- test/signed_integer_to_radix_text_test.sv -----
// testbench for the signed integer to radix text converter
module signed_integer_to_radix_text_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sirt_pkg::*;

  localparam int SETTLE_CYCLES = 300;
  localparam int RANDOM_ITEMS  = 460;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);

  typedef enum int {BAD_SHORT, BAD_LONG, BAD_CHAR, BAD_REPEAT} bad_base_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  class radix_text_scoreboard;
    logic [63:0] chars_lo;
    logic [63:0] chars_hi;
    logic [4:0]  digit_count;
    text_char_t  expected_text[$];
    int          errors;

    function new();
      chars_lo = '0;
      chars_hi = '0;
      digit_count = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
      case (idx)
        REG_DIGITS_LOW:  chars_lo = data;
        REG_DIGITS_HIGH: chars_hi = data;
        REG_BASE_LENGTH: digit_count = data[4:0];
        default: ;
      endcase
    endfunction

    function logic [7:0] table_char(int idx);
      if (idx < 8) return chars_lo[8*idx +: 8];
      return chars_hi[8*(idx-8) +: 8];
    endfunction

    function bit radix_ok();
      logic [7:0] c;
      if (digit_count < 2 || digit_count > MAX_RADIX) return 1'b0;
      for (int a = 0; a < digit_count; a++) begin
        c = table_char(a);
        if (c == NUL_CHAR || c == PLUS_CHAR || c == MINUS_CHAR) return 1'b0;
        for (int b = 0; b < a; b++)
          if (table_char(b) == c) return 1'b0;
      end
      return 1'b1;
    endfunction

    // expected characters of one accepted request
    function void note_number(logic [VALUE_BITS-1:0] raw);
      logic [VALUE_BITS-1:0] mag;
      logic [VALUE_BITS-1:0] radix;
      int digit_idx[$];
      text_char_t c;
      if (!radix_ok()) return;
      radix = VALUE_BITS'(digit_count);
      // most negative value negates onto itself, which is the right magnitude
      mag = raw[VALUE_BITS-1] ? -raw : raw;
      do begin
        digit_idx.push_front(int'(mag % radix));
        mag = mag / radix;
      end while (mag != 0);
      if (raw[VALUE_BITS-1]) begin
        c.ch = MINUS_CHAR;
        c.last = 1'b0;
        expected_text.push_back(c);
      end
      foreach (digit_idx[i]) begin
        c.ch = table_char(digit_idx[i]);
        c.last = (i == digit_idx.size() - 1);
        expected_text.push_back(c);
      end
    endfunction

    function void check_char(logic [7:0] ch, logic last);
      text_char_t want;
      if (expected_text.size() == 0) begin
        $error("text_char %h last_char %b with no character expected", ch, last);
        errors++;
        return;
      end
      want = expected_text.pop_front();
      if (ch !== want.ch) begin
        $error("text_char expected %h actual %h", want.ch, ch);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_char expected %b actual %b", want.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_text.size();
    endfunction
  endclass

  radix_text_scoreboard sb;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          in_valid;
  logic                          in_ready;
  logic signed [VALUE_BITS-1:0]  value;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [7:0]                    text_char;
  logic                          last_char;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [CFG_IDX_W-1:0]          cfg_index;
  logic [CFG_DATA_W-1:0]         cfg_data;
  logic [9:0]                    stall_count = '0;

  signed_integer_to_radix_text u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .text_char (text_char),
    .last_char (last_char),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver rotates through always ready, light, periodic and heavy stalls
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      stall_count <= stall_count + 10'd1;
      case (stall_count[9:8])
        2'd0:    out_ready <= 1'b1;
        2'd1:    out_ready <= ($urandom_range(0, 3) != 0);
        2'd2:    out_ready <= (stall_count[2:0] == 3'd5);
        default: out_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_char(text_char, last_char);
  end

  task automatic send_number(input logic [VALUE_BITS-1:0] v);
    in_valid <= 1'b1;
    value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_number(v);
  endtask

  task automatic hold_off(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // no writes until all text is out and any silent request has finished
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic apply_table(input logic [63:0] lo, input logic [63:0] hi,
                             input logic [63:0] len_word, input bit poke_unused);
    drain();
    write_reg(REG_DIGITS_LOW, lo);
    write_reg(REG_DIGITS_HIGH, hi);
    write_reg(REG_BASE_LENGTH, len_word);
    if (poke_unused) write_reg(REG_UNUSED, {$urandom, $urandom});
    cfg_valid <= 1'b0;
  endtask

  task automatic random_table(input bit good);
    logic [7:0]  tbl [16];
    bit [255:0]  used;
    int          len;
    int          a;
    int          b;
    bad_base_t   flaw;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] len_word;
    used = '0;
    flaw = bad_base_t'($urandom_range(0, 3));
    case ($urandom_range(0, 3))
      0:       len = 2;
      1:       len = MAX_RADIX;
      default: len = $urandom_range(2, MAX_RADIX);
    endcase
    for (int i = 0; i < 16; i++) begin
      if (i < len) begin
        do tbl[i] = 8'($urandom_range(1, 255));
        while (tbl[i] == PLUS_CHAR || tbl[i] == MINUS_CHAR || used[tbl[i]]);
        used[tbl[i]] = 1'b1;
      end else begin
        tbl[i] = 8'($urandom_range(0, 255));
      end
    end
    if (!good) begin
      case (flaw)
        BAD_SHORT: len = $urandom_range(0, 1);
        BAD_LONG:  len = $urandom_range(MAX_RADIX + 1, 31);
        BAD_CHAR: begin
          a = $urandom_range(0, len - 1);
          case ($urandom_range(0, 2))
            0:       tbl[a] = NUL_CHAR;
            1:       tbl[a] = PLUS_CHAR;
            default: tbl[a] = MINUS_CHAR;
          endcase
        end
        default: begin
          b = $urandom_range(1, len - 1);
          a = $urandom_range(0, b - 1);
          tbl[b] = tbl[a];
        end
      endcase
    end
    for (int i = 0; i < 8; i++) begin
      lo[8*i +: 8] = tbl[i];
      hi[8*i +: 8] = tbl[i+8];
    end
    // upper bits of the length word must be dropped
    len_word = {$urandom, $urandom};
    len_word[4:0] = 5'(len);
    apply_table(lo, hi, len_word, $urandom_range(0, 7) == 0);
  endtask

  function automatic logic [VALUE_BITS-1:0] random_value();
    logic [VALUE_BITS-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = {1'b1, {(VALUE_BITS-1){1'b0}}} + $urandom_range(0, 3);
      1:       v = {1'b0, {(VALUE_BITS-1){1'b1}}} - $urandom_range(0, 3);
      2, 3:    v = $urandom_range(0, 300);
      4, 5, 6: v = $urandom >> $urandom_range(0, VALUE_BITS - 1);
      default: v = $urandom;
    endcase
    if ($urandom_range(0, 1) && v[VALUE_BITS-1] == 1'b0) v = -v;
    return v;
  endfunction

  initial begin
    int  sent;
    int  phase_no;
    int  phase_len;
    int  burst_left;
    bit  bursty;
    bit  good;
    logic [63:0] hex_lo;
    logic [63:0] hex_hi;
    sb = new();
    rst <= 1'b1;
    in_valid <= 1'b0;
    value <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset table has length zero, so nothing comes out
    send_number(32'sd5);
    send_number(-32'sd5);

    apply_table("76543210", 64'h0000_0000_0000_3938, 64'd10, 1'b1);
    send_number(32'sd0);
    send_number(32'sd1);
    send_number(-32'sd1);
    send_number(32'h7fff_ffff);
    send_number(32'h8000_0000);
    send_number(32'sd10);
    send_number(-32'sd9);
    send_number(32'sd1234567890);

    // bytes past the length hold bad characters and must be ignored
    apply_table(64'h2d00_2b2d_0000_3130, 64'h2d2d_2b2b_0000_2d00, 64'd2, 1'b0);
    send_number(32'h8000_0000);
    send_number(32'h7fff_ffff);
    send_number(32'haaaa_aaaa);
    send_number(32'h5555_5555);

    hex_lo = 64'hff80_7f01_3332_3130;
    hex_hi = 64'hfec3_a55a_4746_4544;
    apply_table(hex_lo, hex_hi, 64'd16, 1'b0);
    send_number(-32'sd1);
    send_number(32'h89ab_cdef);
    send_number(32'sd0);

    // invalid bases: none of these may produce text
    apply_table(hex_lo, hex_hi, 64'd1, 1'b0);
    send_number(-32'sd12345);
    apply_table(hex_lo, hex_hi, 64'd17, 1'b0);
    send_number(32'sd12345);
    apply_table({hex_lo[63:32], 8'h2b, hex_lo[23:0]}, hex_hi, 64'd16, 1'b0);
    send_number(32'sd77);
    apply_table(hex_lo, {8'h2d, hex_hi[55:0]}, 64'd16, 1'b0);
    send_number(-32'sd77);
    apply_table({hex_lo[63:8], 8'h00}, hex_hi, 64'd2, 1'b0);
    send_number(32'sd3);
    apply_table(hex_lo, {8'hff, hex_hi[55:0]}, 64'd16, 1'b0);
    send_number(32'sd300);

    sent = 0;
    phase_no = 0;
    while (sent < RANDOM_ITEMS) begin
      good = ($urandom_range(0, 6) != 0);
      random_table(good);
      phase_len = good ? $urandom_range(8, 40) : $urandom_range(2, 6);
      bursty = ($urandom_range(0, 2) != 0);
      burst_left = 0;
      for (int k = 0; k < phase_len; k++) begin
        if (phase_no == 1 && k == phase_len / 2) begin
          // let the block run dry before the next request
          in_valid <= 1'b0;
          @(posedge clk);
          while (sb.pending() != 0) @(posedge clk);
        end else if (bursty && burst_left == 0) begin
          hold_off(($urandom_range(0, 3) == 0) ? $urandom_range(30, 260)
                                               : $urandom_range(1, 12));
          burst_left = $urandom_range(1, 10);
        end
        if (burst_left > 0) burst_left--;
        send_number(random_value());
        if (good) sent++;
      end
      phase_no++;
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("signed_integer_to_radix_text_test passed");
    end else begin
      $display("signed_integer_to_radix_text_test failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("signed_integer_to_radix_text_test failed");
    $finish;
  end

endmodule
